// ===== sv/plc_rfb_pkg.sv =====
// Types, constants and helper functions shared by the PLC read request frame builder.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package plc_rfb_pkg;

  localparam int unsigned FrameLen  = 17;
  localparam int unsigned IdxW      = $clog2(FrameLen);
  localparam logic [IdxW-1:0] IdxLast = IdxW'(FrameLen - 1);
  localparam logic [IdxW-1:0] IdxLrcLo = IdxW'(FrameLen - 3);
  localparam logic [IdxW-1:0] IdxCr    = IdxW'(FrameLen - 2);

  localparam logic [7:0] CharColon = 8'h3A;
  localparam logic [7:0] CharCr    = 8'h0D;
  localparam logic [7:0] CharLf    = 8'h0A;
  localparam logic [7:0] HexDigit0 = 8'h30;
  localparam logic [7:0] HexAlpha  = 8'h37;

  localparam logic [7:0] FuncBitRead  = 8'h02;
  localparam logic [7:0] FuncWordRead = 8'h03;

  localparam logic [15:0] OffsM = 16'h0800;
  localparam logic [15:0] OffsY = 16'h0500;
  localparam logic [15:0] OffsX = 16'h0400;
  localparam logic [15:0] OffsD = 16'h1000;
  localparam logic [15:0] OffsT = 16'h0600;
  localparam logic [15:0] OffsC = 16'h0E00;

  typedef enum logic [2:0] {
    CLS_M     = 3'd0,
    CLS_Y     = 3'd1,
    CLS_X     = 3'd2,
    CLS_D     = 3'd3,
    CLS_T     = 3'd4,
    CLS_C     = 3'd5,
    CLS_OTHER = 3'd6
  } reg_class_e;

  typedef struct packed {
    logic [7:0] node_address;
    logic [2:0] register_class;
    logic [3:0] digit_thousands;
    logic [3:0] digit_hundreds;
    logic [3:0] digit_tens;
    logic [3:0] digit_units;
    logic [7:0] block_size;
    logic       force_single;
  } req_t;

  typedef struct packed {
    logic [7:0] frame_char;
    logic       last_char;
  } rsp_t;

  typedef struct packed {
    logic [7:0] node;
    logic [7:0] func;
    logic [7:0] addr_hi;
    logic [7:0] addr_lo;
    logic [7:0] qty;
    logic [7:0] lrc;
  } frame_t;

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] wide;
    wide = {4'd0, nib};
    if (nib < 4'd10) begin
      hex_char = wide + HexDigit0;
    end else begin
      hex_char = wide + HexAlpha;
    end
  endfunction

endpackage

`default_nettype wire

// ===== sv/plc_rfb_compose.sv =====
// Combinational composition of the frame bytes (address, function, quantity, LRC).
// Depends on plc_rfb_pkg.
`default_nettype none

module plc_rfb_compose (
  input  plc_rfb_pkg::req_t   req_i,
  output plc_rfb_pkg::frame_t frame_o
);
  import plc_rfb_pkg::*;

  logic [15:0] oct_addr;
  logic [15:0] dec_addr;
  logic [15:0] base_addr;
  logic [15:0] offs;
  logic [15:0] addr;
  logic [7:0]  func;
  logic [7:0]  qty;
  logic [7:0]  sum;

  always_comb begin
    oct_addr = {3'd0, req_i.digit_thousands, 9'd0} + {6'd0, req_i.digit_hundreds, 6'd0}
             + {9'd0, req_i.digit_tens, 3'd0} + {12'd0, req_i.digit_units};
    dec_addr = ({12'd0, req_i.digit_thousands} * 16'd1000)
             + ({12'd0, req_i.digit_hundreds} * 16'd100)
             + ({12'd0, req_i.digit_tens} * 16'd10) + {12'd0, req_i.digit_units};
    base_addr = dec_addr;
    offs      = 16'd0;
    func      = FuncWordRead;
    unique case (req_i.register_class)
      CLS_M: begin
        offs = OffsM;
        func = FuncBitRead;
      end
      CLS_Y: begin
        base_addr = oct_addr;
        offs      = OffsY;
        func      = FuncBitRead;
      end
      CLS_X: begin
        base_addr = oct_addr;
        offs      = OffsX;
        func      = FuncBitRead;
      end
      CLS_D: offs = OffsD;
      CLS_T: offs = OffsT;
      CLS_C: offs = OffsC;
      default: offs = 16'd0;
    endcase
    addr = base_addr + offs;
    qty  = req_i.force_single ? 8'd1 : req_i.block_size;
    sum  = req_i.node_address + func + addr[15:8] + addr[7:0] + qty;

    frame_o.node    = req_i.node_address;
    frame_o.func    = func;
    frame_o.addr_hi = addr[15:8];
    frame_o.addr_lo = addr[7:0];
    frame_o.qty     = qty;
    frame_o.lrc     = 8'd0 - sum;
  end

endmodule

`default_nettype wire

// ===== sv/plc_rfb_serialiser.sv =====
// Frame register, character counter and output register that send a frame as ASCII.
// Depends on plc_rfb_pkg.
`default_nettype none

module plc_rfb_serialiser (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                frame_valid_i,
  output logic                frame_ready_o,
  input  plc_rfb_pkg::frame_t frame_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output plc_rfb_pkg::rsp_t   out_rsp_o
);
  import plc_rfb_pkg::*;

  frame_t          frame_q, frame_d;
  logic            active_q, active_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic            out_valid_q, out_valid_d;
  rsp_t            out_q, out_d;

  logic            out_free;
  logic            load;
  logic [IdxW-1:0] nib_pos;
  logic [7:0]      sel_byte;
  logic [3:0]      sel_nib;
  logic [7:0]      char_c;

  assign out_free      = !out_valid_q || !out_stall_i;
  assign frame_ready_o = !active_q || (out_free && idx_q == IdxLast);
  assign load          = frame_valid_i && frame_ready_o;

  always_comb begin
    nib_pos = idx_q - IdxW'(1);
    unique case (nib_pos[3:1])
      3'd0:    sel_byte = frame_q.node;
      3'd1:    sel_byte = frame_q.func;
      3'd2:    sel_byte = frame_q.addr_hi;
      3'd3:    sel_byte = frame_q.addr_lo;
      3'd4:    sel_byte = 8'd0;
      3'd5:    sel_byte = frame_q.qty;
      default: sel_byte = frame_q.lrc;
    endcase
    sel_nib = nib_pos[0] ? sel_byte[3:0] : sel_byte[7:4];
    priority if (idx_q == '0) begin
      char_c = CharColon;
    end else if (idx_q <= IdxLrcLo) begin
      char_c = hex_char(sel_nib);
    end else if (idx_q == IdxCr) begin
      char_c = CharCr;
    end else begin
      char_c = CharLf;
    end
  end

  always_comb begin
    frame_d     = frame_q;
    active_d    = active_q;
    idx_d       = idx_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (out_free) begin
      out_valid_d = active_q;
      out_d.frame_char = char_c;
      out_d.last_char  = (idx_q == IdxLast);
      if (active_q) begin
        if (idx_q == IdxLast) begin
          active_d = 1'b0;
          idx_d    = '0;
        end else begin
          idx_d = idx_q + IdxW'(1);
        end
      end
    end
    if (load) begin
      frame_d  = frame_i;
      active_d = 1'b1;
      idx_d    = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      active_q    <= active_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    frame_q <= frame_d;
    out_q   <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q <= IdxLast)
    else $error("character counter beyond the end of the frame");

  a_last_is_lf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.last_char |-> out_q.frame_char == CharLf)
    else $error("last character is not a line feed");

  a_frame_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_stall_i && !out_q.last_char |=> out_valid_q)
    else $error("gap inside a frame");

  a_load_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> active_q && idx_q == '0)
    else $error("new frame did not start at its first character");

endmodule

`default_nettype wire

// ===== sv/plc_read_request_frame_builder.sv =====
// A request taken into the input register moves to the serialiser's frame register,
// and its first character is then registered in the output register. One character
// per cycle while the output is not stalled; the next request waits in the input
// register while a frame is sent. Reset clears all valid flags and the counter.
// Top level of the PLC read request frame builder; uses plc_rfb_pkg and its submodules.
`default_nettype none

module plc_read_request_frame_builder (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  plc_rfb_pkg::req_t in_req_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output plc_rfb_pkg::rsp_t out_rsp_o
);
  import plc_rfb_pkg::*;

  req_t   req_q, req_d;
  logic   req_valid_q, req_valid_d;
  frame_t frame;
  logic   frame_ready;

  assign in_stall_o = req_valid_q && !frame_ready;

  always_comb begin
    req_d       = req_q;
    req_valid_d = req_valid_q;
    if (frame_ready) begin
      req_valid_d = 1'b0;
    end
    if (in_valid_i && !in_stall_o) begin
      req_d       = in_req_i;
      req_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
    end else begin
      req_valid_q <= req_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q <= req_d;
  end

  plc_rfb_compose u_compose (
    .req_i   (req_q),
    .frame_o (frame)
  );

  plc_rfb_serialiser u_serialiser (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .frame_valid_i (req_valid_q),
    .frame_ready_o (frame_ready),
    .frame_i       (frame),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_rsp_o     (out_rsp_o)
  );

endmodule

`default_nettype wire

// ===== sim/frame_char_checker.sv =====
// Checker for the PLC read request frame builder: predicts the seventeen frame characters of
// every accepted request and compares them with the characters the block sends.
// Depends on plc_rfb_pkg for the request and response types and the frame constants.
`default_nettype none

module frame_char_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  plc_rfb_pkg::req_t  in_req_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  plc_rfb_pkg::rsp_t  out_rsp_i,
  output int unsigned        fail_count_o,
  output int unsigned        pending_count_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import plc_rfb_pkg::*;

  rsp_t        pending_chars[$];
  int unsigned fails;

  function automatic logic [7:0] ascii_nibble(input logic [3:0] nib);
    logic [7:0] val;
    val = {4'd0, nib};
    return (nib < 4'd10) ? val + HexDigit0 : val + HexAlpha;
  endfunction

  function automatic rsp_t frame_item(input logic [7:0] ch, input logic is_last);
    rsp_t item;
    item.frame_char = ch;
    item.last_char  = is_last;
    return item;
  endfunction

  task automatic queue_frame(input req_t req);
    logic [15:0] word_addr;
    logic [15:0] d3;
    logic [15:0] d2;
    logic [15:0] d1;
    logic [15:0] d0;
    logic [7:0]  func;
    logic [7:0]  lrc_sum;
    logic [7:0]  frame_bytes[6];
    d3 = {12'd0, req.digit_thousands};
    d2 = {12'd0, req.digit_hundreds};
    d1 = {12'd0, req.digit_tens};
    d0 = {12'd0, req.digit_units};
    func = FuncWordRead;
    case (reg_class_e'(req.register_class))
      CLS_Y, CLS_X: word_addr = d3 * 16'd512 + d2 * 16'd64 + d1 * 16'd8 + d0;
      default:      word_addr = d3 * 16'd1000 + d2 * 16'd100 + d1 * 16'd10 + d0;
    endcase
    case (reg_class_e'(req.register_class))
      CLS_M: begin
        word_addr = word_addr + OffsM;
        func = FuncBitRead;
      end
      CLS_Y: begin
        word_addr = word_addr + OffsY;
        func = FuncBitRead;
      end
      CLS_X: begin
        word_addr = word_addr + OffsX;
        func = FuncBitRead;
      end
      CLS_D:   word_addr = word_addr + OffsD;
      CLS_T:   word_addr = word_addr + OffsT;
      CLS_C:   word_addr = word_addr + OffsC;
      default: word_addr = word_addr;
    endcase
    frame_bytes[0] = req.node_address;
    frame_bytes[1] = func;
    frame_bytes[2] = word_addr[15:8];
    frame_bytes[3] = word_addr[7:0];
    frame_bytes[4] = 8'h00;
    frame_bytes[5] = req.force_single ? 8'h01 : req.block_size;
    lrc_sum = 8'h00;
    pending_chars.push_back(frame_item(CharColon, 1'b0));
    foreach (frame_bytes[i]) begin
      lrc_sum = lrc_sum + frame_bytes[i];
      pending_chars.push_back(frame_item(ascii_nibble(frame_bytes[i][7:4]), 1'b0));
      pending_chars.push_back(frame_item(ascii_nibble(frame_bytes[i][3:0]), 1'b0));
    end
    lrc_sum = 8'h00 - lrc_sum;
    pending_chars.push_back(frame_item(ascii_nibble(lrc_sum[7:4]), 1'b0));
    pending_chars.push_back(frame_item(ascii_nibble(lrc_sum[3:0]), 1'b0));
    pending_chars.push_back(frame_item(CharCr, 1'b0));
    pending_chars.push_back(frame_item(CharLf, 1'b1));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    rsp_t want;
    if (!rst_ni) begin
      pending_chars.delete();
      fails = 0;
      fail_count_o    <= 0;
      pending_count_o <= 0;
    end else begin
      if (in_valid_i && !in_stall_i) begin
        queue_frame(in_req_i);
      end
      if (out_valid_i && !out_stall_i) begin
        if (pending_chars.size() == 0) begin
          $error("unexpected character %h with no request outstanding", out_rsp_i.frame_char);
          fails++;
        end else begin
          want = pending_chars.pop_front();
          if (out_rsp_i.frame_char !== want.frame_char) begin
            $error("frame_char: expected %h, actual %h", want.frame_char, out_rsp_i.frame_char);
            fails++;
          end
          if (out_rsp_i.last_char !== want.last_char) begin
            $error("last_char: expected %b, actual %b", want.last_char, out_rsp_i.last_char);
            fails++;
          end
        end
      end
      fail_count_o    <= fails;
      pending_count_o <= pending_chars.size();
    end
  end

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
// Top of the frame builder testbench: clock, reset, request stimulus and random stalls.
// Depends on plc_rfb_pkg, the block itself and frame_char_checker, which does the comparing.
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import plc_rfb_pkg::*;

  localparam int unsigned      IdleLimit   = 5000;
  localparam int unsigned      RandomItems = 94;
  localparam logic [2:0]       ClsUnused   = 3'd7;

  logic        clk_i;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  req_t        in_req;
  logic        out_valid;
  logic        out_stall = 1'b1;
  rsp_t        out_rsp;
  logic        no_idle   = 1'b0;
  int unsigned fail_count;
  int unsigned pending_count;
  int unsigned idle_cycles;
  int unsigned stall_left;
  int unsigned stall_roll;

  plc_read_request_frame_builder u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_req_i    (in_req),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_rsp_o   (out_rsp)
  );

  frame_char_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_i      (in_stall),
    .in_req_i        (in_req),
    .out_valid_i     (out_valid),
    .out_stall_i     (out_stall),
    .out_rsp_i       (out_rsp),
    .fail_count_o    (fail_count),
    .pending_count_o (pending_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(negedge clk_i) begin
    if (stall_left == 0 && !no_idle) begin
      stall_roll = $urandom_range(0, 15);
      if (stall_roll < 10) begin
        stall_left = 0;
      end else if (stall_roll < 14) begin
        stall_left = $urandom_range(1, 3);
      end else begin
        stall_left = $urandom_range(8, 40);
      end
    end
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IdleLimit) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 19);
    if (no_idle || roll < 12) begin
      return 0;
    end else if (roll < 18) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  function automatic req_t make_req(input logic [7:0] node, input logic [2:0] cls,
                                    input logic [3:0] d3, input logic [3:0] d2,
                                    input logic [3:0] d1, input logic [3:0] d0,
                                    input logic [7:0] blk, input logic single);
    req_t req;
    req.node_address    = node;
    req.register_class  = cls;
    req.digit_thousands = d3;
    req.digit_hundreds  = d2;
    req.digit_tens      = d1;
    req.digit_units     = d0;
    req.block_size      = blk;
    req.force_single    = single;
    return req;
  endfunction

  function automatic req_t random_req();
    logic [3:0] digit_max;
    logic [2:0] cls;
    logic [7:0] blk;
    digit_max = ($urandom_range(0, 6) == 0) ? 4'd15 : 4'd9;
    cls = ($urandom_range(0, 9) == 0) ? ClsUnused : 3'($urandom_range(CLS_M, CLS_OTHER));
    case ($urandom_range(0, 9))
      0:       blk = 8'h00;
      1:       blk = 8'hFF;
      default: blk = 8'($urandom_range(0, 255));
    endcase
    return make_req(8'($urandom_range(0, 255)), cls,
                    4'($urandom_range(0, digit_max)), 4'($urandom_range(0, digit_max)),
                    4'($urandom_range(0, digit_max)), 4'($urandom_range(0, digit_max)),
                    blk, 1'($urandom_range(0, 1)));
  endfunction

  task automatic send_request(input req_t req);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid <= 1'b1;
    in_req   <= req;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  initial begin
    in_valid    = 1'b0;
    in_req      = '0;
    rst_n       = 1'b0;
    idle_cycles = 0;
    stall_left  = 0;
    repeat (10) @(negedge clk_i);
    rst_n = 1'b1;
    @(negedge clk_i);

    // Extremes of every field, each register class, digits above nine and the D1000 boundary.
    send_request(make_req(8'h00, CLS_M, 4'd0, 4'd0, 4'd0, 4'd0, 8'h00, 1'b0));
    send_request(make_req(8'hFF, CLS_Y, 4'd7, 4'd7, 4'd7, 4'd7, 8'hFF, 1'b0));
    send_request(make_req(8'h01, CLS_X, 4'd7, 4'd7, 4'd7, 4'd7, 8'h01, 1'b1));
    send_request(make_req(8'h11, CLS_D, 4'd9, 4'd9, 4'd9, 4'd9, 8'h0A, 1'b0));
    send_request(make_req(8'h7F, CLS_D, 4'd1, 4'd0, 4'd0, 4'd0, 8'h7F, 1'b0));
    send_request(make_req(8'h80, CLS_D, 4'd0, 4'd9, 4'd9, 4'd9, 8'h80, 1'b0));
    send_request(make_req(8'h20, CLS_T, 4'd0, 4'd0, 4'd0, 4'd0, 8'h00, 1'b1));
    send_request(make_req(8'hFE, CLS_C, 4'd9, 4'd9, 4'd9, 4'd9, 8'hFF, 1'b0));
    send_request(make_req(8'h5A, CLS_OTHER, 4'd1, 4'd2, 4'd3, 4'd4, 8'hFF, 1'b1));
    send_request(make_req(8'hA5, ClsUnused, 4'd5, 4'd6, 4'd7, 4'd8, 8'h10, 1'b0));
    send_request(make_req(8'hAB, CLS_X, 4'd15, 4'd15, 4'd15, 4'd15, 8'h00, 1'b0));
    send_request(make_req(8'hCD, CLS_Y, 4'd9, 4'd8, 4'd9, 4'd8, 8'h55, 1'b0));
    send_request(make_req(8'hEF, CLS_M, 4'd15, 4'd15, 4'd15, 4'd15, 8'hAA, 1'b1));
    send_request(make_req(8'h3C, CLS_C, 4'd15, 4'd15, 4'd15, 4'd15, 8'h00, 1'b0));
    send_request(make_req(8'hC3, ClsUnused, 4'd15, 4'd15, 4'd15, 4'd15, 8'hFF, 1'b0));
    send_request(make_req(8'h00, CLS_OTHER, 4'd0, 4'd0, 4'd0, 4'd0, 8'h00, 1'b0));

    for (int i = 0; i < RandomItems; i++) begin
      if (i % 10 == 0) begin
        no_idle <= ($urandom_range(0, 3) == 0);
      end
      send_request(random_req());
    end
    in_valid <= 1'b0;
    no_idle  <= 1'b0;

    while (pending_count != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== files.f =====
sv/plc_rfb_pkg.sv
sv/plc_rfb_compose.sv
sv/plc_rfb_serialiser.sv
sv/plc_read_request_frame_builder.sv
sim/frame_char_checker.sv
sim/testbench.sv
